// ===== rtl/core/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;
	localparam int NUM_PAGES = 65536;
	localparam int MAX_RUN = 256;
	localparam int WORD_W = 128;
	localparam int BIT_W = $clog2(WORD_W);
	localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW = $clog2(NUM_PAGES) + 1;
	localparam int CW = $clog2(MAX_RUN + 1);
	localparam int CNT_W = 17;
	localparam int TOTAL = (NUM_PAGES > 131071) ? 131071 : NUM_PAGES;

	localparam logic [2:0] MODE_REQ = 3'd0;
	localparam logic [2:0] MODE_LOCK = 3'd1;
	localparam logic [2:0] MODE_FREE = 3'd2;
	localparam logic [2:0] MODE_RES = 3'd3;
	localparam logic [2:0] MODE_UNRES = 3'd4;

	localparam logic [1:0] REG_FREE = 2'd0;
	localparam logic [1:0] REG_USED = 2'd1;
	localparam logic [1:0] REG_RES = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [15:0] page_index;
		logic [8:0] run_length;
	} req_t;

	typedef struct packed {
		logic found;
		logic [15:0] found_index;
		logic [16:0] free_pages;
		logic [16:0] used_pages;
		logic [16:0] reserved_pages;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [1:0] idx;
		logic [16:0] val;
	} cfg_wr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_LATCH,
		ST_STEP,
		ST_WB,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// Top level: APB register file, item handshakes and result register.
// Apply modes walk the run one page at a time, loading each 128-page word touched and writing back each changed word.
// A request scans one page per cycle from page 0, pausing to load each 128-page word,
// then, if a run is found, runs the lock pass over it.
// One item at a time; the result register lets the next item in while a result waits.
// After reset a clearing pass writes all 512 map words to zero, marking all pages free.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic req_valid,
	output logic req_ready,
	input wire bpfa_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output bpfa_pkg::rsp_t rsp
);
	logic [16:0] sfree_q, sused_q, sres_q;
	logic out_valid_q, eng_idle, eng_done, done_ack;
	bpfa_pkg::rsp_t out_q, eng_res;
	bpfa_pkg::cfg_wr_t cfg;

	assign pready = 1'b1;
	assign cfg.we = psel && penable && pwrite;
	assign cfg.idx = paddr[3:2];
	assign cfg.val = pwdata[16:0];

	always_comb begin
		case (paddr[3:2])
			bpfa_pkg::REG_FREE: prdata = {15'd0, sfree_q};
			bpfa_pkg::REG_USED: prdata = {15'd0, sused_q};
			bpfa_pkg::REG_RES: prdata = {15'd0, sres_q};
			default: prdata = '0;
		endcase
	end

	assign req_ready = eng_idle;
	assign done_ack = eng_done && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	bpfa_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.start(req_valid && eng_idle),
		.cmd(req),
		.idle(eng_idle),
		.done(eng_done),
		.done_ack(done_ack),
		.result(eng_res)
	);

	always_ff @(posedge clk) begin
		if (done_ack) out_q <= eng_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sfree_q <= '0;
			sused_q <= '0;
			sres_q <= '0;
		end else begin
			if (done_ack) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
			if (cfg.we) begin
				case (cfg.idx)
					bpfa_pkg::REG_FREE: sfree_q <= cfg.val;
					bpfa_pkg::REG_USED: sused_q <= cfg.val;
					bpfa_pkg::REG_RES: sres_q <= cfg.val;
					default: begin
					end
				endcase
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("accepted a second item while busy");
	a_ack_room: assert property (@(posedge clk) disable iff (!arst_n)
		done_ack |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten before taken");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_done && !done_ack) |=> eng_done)
		else $error("finished item dropped");
endmodule
`default_nettype wire

// ===== rtl/core/bpfa_engine.sv =====
// Page map memory, counters and the page-at-a-time search and update sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire bpfa_pkg::cfg_wr_t cfg,
	input wire logic start,
	input wire bpfa_pkg::req_t cmd,
	output logic idle,
	output logic done,
	input wire logic done_ack,
	output bpfa_pkg::rsp_t result
);
	localparam logic [bpfa_pkg::CNT_W-1:0] TOT = bpfa_pkg::CNT_W'(bpfa_pkg::TOTAL);

	bpfa_pkg::state_t state_q, state_n;
	logic [bpfa_pkg::WORD_W-1:0] mem [bpfa_pkg::WORDS];
	logic [bpfa_pkg::WORD_W-1:0] rd_q, word_q, word_n;
	logic [bpfa_pkg::AW-1:0] clr_q, wa_q, ra;
	logic [bpfa_pkg::PW-1:0] page_q, page_n, start_pg;
	logic [bpfa_pkg::CW-1:0] cnt_q, cnt_n, left_q, left_n, len_q, len_eff;
	logic [2:0] op_q;
	logic srch_q, dirty_q, dirty_n, fin_q, found_q;
	logic [15:0] fidx_q;
	logic [bpfa_pkg::CNT_W-1:0] free_q, used_q, res_q, free_n, used_n, res_n;
	logic [bpfa_pkg::BIT_W-1:0] bi;
	logic bit_v, s_found, s_fail, a_end, boundary, mem_we;

	function automatic logic [bpfa_pkg::CNT_W-1:0] inc_sat(input logic [bpfa_pkg::CNT_W-1:0] v);
		return (v >= TOT) ? TOT : v + 1'b1;
	endfunction
	function automatic logic [bpfa_pkg::CNT_W-1:0] dec_sat(input logic [bpfa_pkg::CNT_W-1:0] v);
		return (v == '0) ? '0 : v - 1'b1;
	endfunction

	assign len_eff = (32'(cmd.run_length) > bpfa_pkg::MAX_RUN) ?
		bpfa_pkg::CW'(bpfa_pkg::MAX_RUN) : bpfa_pkg::CW'(cmd.run_length);
	assign ra = bpfa_pkg::AW'(page_q >> bpfa_pkg::BIT_W);
	assign bi = bpfa_pkg::BIT_W'(page_q);
	assign bit_v = word_q[bi];
	assign boundary = (bi == {bpfa_pkg::BIT_W{1'b1}});
	assign page_n = page_q + 1'b1;
	assign start_pg = page_n - bpfa_pkg::PW'(cnt_n);

	// per-page datapath
	always_comb begin
		word_n = word_q;
		dirty_n = dirty_q;
		free_n = free_q;
		used_n = used_q;
		res_n = res_q;
		cnt_n = cnt_q;
		s_found = 1'b0;
		s_fail = 1'b0;
		left_n = left_q - 1'b1;
		a_end = (left_n == '0) || (32'(page_n) >= bpfa_pkg::NUM_PAGES);
		if (srch_q) begin
			if (bit_v) begin
				cnt_n = '0;
				s_fail = (32'(page_q) >= 65536);
			end else begin
				cnt_n = cnt_q + 1'b1;
				if (32'(start_pg) >= 65536) s_fail = 1'b1;
				else if (cnt_n == len_q) s_found = 1'b1;
			end
			if (!s_found && 32'(page_q) == bpfa_pkg::NUM_PAGES - 1) s_fail = 1'b1;
		end else begin
			case (op_q) inside
				bpfa_pkg::MODE_LOCK, bpfa_pkg::MODE_RES: begin
					if (!bit_v) begin
						word_n[bi] = 1'b1;
						dirty_n = 1'b1;
						free_n = dec_sat(free_q);
						if (op_q == bpfa_pkg::MODE_RES) res_n = inc_sat(res_q);
						else used_n = inc_sat(used_q);
					end
				end
				default: begin
					if (bit_v) begin
						word_n[bi] = 1'b0;
						dirty_n = 1'b1;
						free_n = inc_sat(free_q);
						if (op_q == bpfa_pkg::MODE_FREE) used_n = dec_sat(used_q);
						else res_n = dec_sat(res_q);
					end
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			bpfa_pkg::ST_CLEAR:
				if (32'(clr_q) == bpfa_pkg::WORDS - 1) state_n = bpfa_pkg::ST_IDLE;
			bpfa_pkg::ST_IDLE: begin
				if (start) begin
					if (len_eff == '0 || cmd.mode > bpfa_pkg::MODE_UNRES ||
						(cmd.mode != bpfa_pkg::MODE_REQ &&
						32'(cmd.page_index) >= bpfa_pkg::NUM_PAGES))
						state_n = bpfa_pkg::ST_DONE;
					else
						state_n = bpfa_pkg::ST_LOAD;
				end
			end
			bpfa_pkg::ST_LOAD: state_n = bpfa_pkg::ST_LATCH;
			bpfa_pkg::ST_LATCH: state_n = bpfa_pkg::ST_STEP;
			bpfa_pkg::ST_STEP: begin
				if (srch_q) begin
					if (s_fail) state_n = bpfa_pkg::ST_DONE;
					else if (s_found || boundary) state_n = bpfa_pkg::ST_LOAD;
				end else if (a_end || boundary) begin
					if (dirty_n) state_n = bpfa_pkg::ST_WB;
					else if (a_end) state_n = bpfa_pkg::ST_DONE;
					else state_n = bpfa_pkg::ST_LOAD;
				end
			end
			bpfa_pkg::ST_WB: state_n = fin_q ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_LOAD;
			bpfa_pkg::ST_DONE: if (done_ack) state_n = bpfa_pkg::ST_IDLE;
			default: state_n = bpfa_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		idle = (state_q == bpfa_pkg::ST_IDLE);
		done = (state_q == bpfa_pkg::ST_DONE);
		mem_we = (state_q == bpfa_pkg::ST_CLEAR) || (state_q == bpfa_pkg::ST_WB);
		result.found = found_q;
		result.found_index = fidx_q;
		result.free_pages = free_q;
		result.used_pages = used_q;
		result.reserved_pages = res_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[(state_q == bpfa_pkg::ST_CLEAR) ? clr_q : wa_q] <=
			(state_q == bpfa_pkg::ST_CLEAR) ? '0 : word_q;
		if (state_q == bpfa_pkg::ST_LOAD) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::ST_CLEAR;
			clr_q <= '0;
			free_q <= '0;
			used_q <= '0;
			res_q <= '0;
			found_q <= 1'b0;
			fidx_q <= '0;
			srch_q <= 1'b0;
			dirty_q <= 1'b0;
			fin_q <= 1'b0;
			op_q <= bpfa_pkg::MODE_REQ;
			page_q <= '0;
			cnt_q <= '0;
			left_q <= '0;
			len_q <= '0;
			wa_q <= '0;
			word_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == bpfa_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				bpfa_pkg::ST_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						fidx_q <= '0;
						op_q <= cmd.mode;
						len_q <= len_eff;
						left_q <= len_eff;
						cnt_q <= '0;
						fin_q <= 1'b0;
						srch_q <= (cmd.mode == bpfa_pkg::MODE_REQ);
						page_q <= (cmd.mode == bpfa_pkg::MODE_REQ) ? '0 :
							bpfa_pkg::PW'(cmd.page_index);
					end
				end
				bpfa_pkg::ST_LATCH: begin
					word_q <= rd_q;
					wa_q <= ra;
					dirty_q <= 1'b0;
				end
				bpfa_pkg::ST_STEP: begin
					if (srch_q) begin
						cnt_q <= cnt_n;
						if (s_found) begin
							// switch to locking the run found
							srch_q <= 1'b0;
							op_q <= bpfa_pkg::MODE_LOCK;
							page_q <= start_pg;
							left_q <= len_q;
							found_q <= 1'b1;
							fidx_q <= 16'(start_pg);
						end else begin
							page_q <= page_n;
						end
					end else begin
						word_q <= word_n;
						dirty_q <= dirty_n;
						free_q <= free_n;
						used_q <= used_n;
						res_q <= res_n;
						page_q <= page_n;
						left_q <= left_n;
						fin_q <= a_end;
					end
				end
				default: begin
				end
			endcase
			if (cfg.we) begin
				case (cfg.idx)
					bpfa_pkg::REG_FREE: free_q <= (cfg.val > TOT) ? TOT : cfg.val;
					bpfa_pkg::REG_USED: used_q <= (cfg.val > TOT) ? TOT : cfg.val;
					bpfa_pkg::REG_RES: res_q <= (cfg.val > TOT) ? TOT : cfg.val;
					default: begin
					end
				endcase
			end
		end
	end

	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpfa_pkg::ST_STEP && srch_q) |-> (cnt_q < len_q))
		else $error("search count reached run length");
	a_wb_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpfa_pkg::ST_WB) |-> dirty_q)
		else $error("write-back of unchanged word");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= TOT) && (used_q <= TOT) && (res_q <= TOT))
		else $error("counter above page total");
	a_found_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpfa_pkg::ST_DONE && found_q) |-> (op_q == bpfa_pkg::MODE_LOCK))
		else $error("grant without lock pass");
endmodule
`default_nettype wire

// ===== tb/sv/bpfa_checker.sv =====
// Checker: tracks the page map and counters, predicts each result and compares.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire bpfa_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire bpfa_pkg::rsp_t rsp,
	output int errors,
	output int pending
);
	bit page_map [0:bpfa_pkg::NUM_PAGES-1];
	int free_cnt, used_cnt, res_cnt;
	bpfa_pkg::rsp_t alloc_due [$];

	assign pending = alloc_due.size();

	function automatic int sat_inc(int v);
		return (v >= bpfa_pkg::TOTAL) ? bpfa_pkg::TOTAL : v + 1;
	endfunction

	function automatic int sat_dec(int v);
		return (v == 0) ? 0 : v - 1;
	endfunction

	task automatic walk_run(logic [2:0] op, int first, int len);
		int p;
		for (int k = 0; k < len; k++) begin
			p = first + k;
			if (p >= bpfa_pkg::NUM_PAGES)
				break;
			if (op == bpfa_pkg::MODE_LOCK || op == bpfa_pkg::MODE_RES) begin
				if (!page_map[p]) begin
					page_map[p] = 1'b1;
					free_cnt = sat_dec(free_cnt);
					if (op == bpfa_pkg::MODE_LOCK)
						used_cnt = sat_inc(used_cnt);
					else
						res_cnt = sat_inc(res_cnt);
				end
			end else if (page_map[p]) begin
				page_map[p] = 1'b0;
				free_cnt = sat_inc(free_cnt);
				if (op == bpfa_pkg::MODE_FREE)
					used_cnt = sat_dec(used_cnt);
				else
					res_cnt = sat_dec(res_cnt);
			end
		end
	endtask

	// first fit: lowest run of free pages; runs must start below 65536
	function automatic bit first_fit(int len, output int start);
		int run;
		run = 0;
		start = 0;
		for (int p = 0; p < bpfa_pkg::NUM_PAGES; p++) begin
			if (page_map[p]) begin
				run = 0;
				if (p >= 65536)
					return 1'b0;
				continue;
			end
			run++;
			if (p + 1 - run >= 65536)
				return 1'b0;
			if (run == len) begin
				start = p + 1 - len;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic predict_alloc(bpfa_pkg::req_t it, output bpfa_pkg::rsp_t r);
		int len, s;
		len = (it.run_length > bpfa_pkg::MAX_RUN) ? bpfa_pkg::MAX_RUN : int'(it.run_length);
		r = '0;
		if (len != 0) begin
			if (it.mode == bpfa_pkg::MODE_REQ) begin
				if (first_fit(len, s)) begin
					walk_run(bpfa_pkg::MODE_LOCK, s, len);
					r.found = 1'b1;
					r.found_index = s[15:0];
				end
			end else if (it.mode <= bpfa_pkg::MODE_UNRES) begin
				walk_run(it.mode, it.page_index, len);
			end
		end
		r.free_pages = free_cnt[16:0];
		r.used_pages = used_cnt[16:0];
		r.reserved_pages = res_cnt[16:0];
	endtask

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bpfa_pkg::rsp_t r;
		int v;
		if (!arst_n) begin
			foreach (page_map[i])
				page_map[i] = 1'b0;
			free_cnt = 0;
			used_cnt = 0;
			res_cnt = 0;
			alloc_due.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				v = pwdata[16:0];
				if (v > bpfa_pkg::TOTAL)
					v = bpfa_pkg::TOTAL;
				case (paddr[3:2])
					bpfa_pkg::REG_FREE: free_cnt = v;
					bpfa_pkg::REG_USED: used_cnt = v;
					bpfa_pkg::REG_RES: res_cnt = v;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (alloc_due.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					r = alloc_due.pop_front();
					if (rsp.found !== r.found)
						report("found", rsp.found, r.found);
					if (rsp.found_index !== r.found_index)
						report("found_index", rsp.found_index, r.found_index);
					if (rsp.free_pages !== r.free_pages)
						report("free_pages", rsp.free_pages, r.free_pages);
					if (rsp.used_pages !== r.used_pages)
						report("used_pages", rsp.used_pages, r.used_pages);
					if (rsp.reserved_pages !== r.reserved_pages)
						report("reserved_pages", rsp.reserved_pages, r.reserved_pages);
				end
			end
			if (req_valid && req_ready) begin
				predict_alloc(req, r);
				alloc_due.push_back(r);
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/bitmap_page_frame_allocator_tb.sv =====
// Testbench top: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator_tb;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 430;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	bpfa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bpfa_pkg::rsp_t rsp;

	int errors, pending;
	int cycles = 0;
	int sent = 0, received = 0;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	always #6 clk = ~clk;

	bitmap_page_frame_allocator dut (.*);

	bpfa_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (rsp_valid && rsp_ready)
			received++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL bitmap_page_frame_allocator");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (2000) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	task automatic reg_write(logic [1:0] idx, int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_counters(int f, int u, int r);
		reg_write(bpfa_pkg::REG_FREE, f);
		reg_write(bpfa_pkg::REG_USED, u);
		reg_write(bpfa_pkg::REG_RES, r);
	endtask

	task automatic send(logic [2:0] m, int idx, int len);
		req <= '{mode: m, page_index: idx[15:0], run_length: len[8:0]};
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (received != sent)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// keep most runs short and low in the map so first-fit scans stay short
	function automatic int pick_len();
		int c;
		c = $urandom_range(0, 19);
		if (c == 0)
			return $urandom_range(0, 511);
		if (c < 4)
			return $urandom_range(17, 64);
		return $urandom_range(1, 16);
	endfunction

	task automatic send_random();
		int c, idx;
		logic [2:0] m;
		c = $urandom_range(0, 99);
		if (c < 30)
			m = bpfa_pkg::MODE_REQ;
		else if (c < 45)
			m = bpfa_pkg::MODE_LOCK;
		else if (c < 72)
			m = bpfa_pkg::MODE_FREE;
		else if (c < 82)
			m = bpfa_pkg::MODE_RES;
		else if (c < 96)
			m = bpfa_pkg::MODE_UNRES;
		else
			m = 3'($urandom_range(5, 7));
		idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
		send(m, idx, pick_len());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_counters(65536, 0, 0);
		send(bpfa_pkg::MODE_REQ, 0, 0);
		send(bpfa_pkg::MODE_REQ, 65535, 1);
		send(bpfa_pkg::MODE_REQ, 0, 511);
		send(bpfa_pkg::MODE_LOCK, 65535, 256);
		send(bpfa_pkg::MODE_LOCK, 65280, 256);
		send(bpfa_pkg::MODE_FREE, 65535, 1);
		send(bpfa_pkg::MODE_RES, 500, 10);
		send(bpfa_pkg::MODE_RES, 505, 10);
		send(bpfa_pkg::MODE_UNRES, 505, 20);
		send(bpfa_pkg::MODE_FREE, 0, 300);
		send(bpfa_pkg::MODE_UNRES, 65280, 256);
		send(3'd5, 65535, 511);
		send(3'd6, 0, 1);
		send(3'd7, 100, 40);
		send(bpfa_pkg::MODE_REQ, 0, 257);
		drain();

		// saturate counters at both ends
		load_counters(0, 131071, 65536);
		send(bpfa_pkg::MODE_LOCK, 0, 8);
		send(bpfa_pkg::MODE_RES, 20, 8);
		send(bpfa_pkg::MODE_FREE, 0, 8);
		send(bpfa_pkg::MODE_UNRES, 20, 8);
		send(bpfa_pkg::MODE_REQ, 0, 4);
		send(bpfa_pkg::MODE_FREE, 0, 300);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				drain();
				case (i / 100)
					0: load_counters(65536, 0, 0);
					1: load_counters(0, 0, 0);
					default: load_counters($urandom_range(0, 131071),
						$urandom_range(0, 131071), $urandom_range(0, 131071));
				endcase
			end
			if (i == 150)
				long_hold = 1'b1;
			if (i == 250) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (received != sent)
					@(posedge clk);
			end
			if (i == RANDOM_ITEMS - 60)
				quiet = 1'b1;
			send_random();
		end
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS bitmap_page_frame_allocator");
		else
			$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_engine.sv
rtl/core/bitmap_page_frame_allocator.sv
tb/sv/bpfa_checker.sv
tb/sv/bitmap_page_frame_allocator_tb.sv
